@@ hdl/dfr_pkg.sv @@
// Shared types and constants for the delimited frame receiver.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dfr_pkg;

   // Payload buffer depth and the address width that follows from it.
   localparam int PAYLOAD_DEPTH = 64;
   localparam int ADDR_W        = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

   // Field widths fixed by the frame format.
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 7;
   localparam int POS_W     = 6;
   localparam int CHECK_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_BYTE_0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_BYTE_1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE_0  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE_1  = 2'd3;

   // Write request from the parser into the payload store.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } store_write_type;

   // Completed frame handed from the parser to the output sequencer.
   typedef struct packed {
      logic               start;
      logic [LEN_W-1:0]   count;
      logic [BYTE_W-1:0]  ident;
      logic [CHECK_W-1:0] check;
   } frame_done_type;

endpackage

@@ hdl/dfr_store.sv @@
// Payload store: a single-port-write, registered-read memory of payload bytes.
// Depends on dfr_pkg for the depth, address width and write request type.
`timescale 1ns / 1ps

module dfr_store
   import dfr_pkg::*;
(
   input  logic              clock,
   input  store_write_type   wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_mem [PAYLOAD_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/dfr_parser.sv @@
// Frame parser: configuration registers and the byte-by-byte frame state machine.
// Depends on dfr_pkg; writes payload bytes into dfr_store and reports finished frames.
`timescale 1ns / 1ps

module dfr_parser
   import dfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wr_data,
   input  logic                 accept,
   input  logic [BYTE_W-1:0]    rx_byte,
   output store_write_type      wr,
   output frame_done_type       done
);

   typedef enum logic [8:0] {
      PH_HEAD0 = 9'b000000001,
      PH_HEAD1 = 9'b000000010,
      PH_IDENT = 9'b000000100,
      PH_LEN   = 9'b000001000,
      PH_DATA  = 9'b000010000,
      PH_CHK0  = 9'b000100000,
      PH_CHK1  = 9'b001000000,
      PH_END0  = 9'b010000000,
      PH_END1  = 9'b100000000
   } phase_type;

   logic [BYTE_W-1:0]  head0_ff, head1_ff, end0_ff, end1_ff;
   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  ident_ff, ident_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [LEN_W-1:0]   fill_next;
   logic [CHECK_W-1:0] check_ff, check_in;

   // Configuration registers; an index beyond the list changes nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         head0_ff <= 8'hFC;
         head1_ff <= 8'hFB;
         end0_ff  <= 8'hFD;
         end1_ff  <= 8'hFE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HEAD_BYTE_0: head0_ff <= csr_wr_data;
            CSR_HEAD_BYTE_1: head1_ff <= csr_wr_data;
            CSR_END_BYTE_0:  end0_ff  <= csr_wr_data;
            CSR_END_BYTE_1:  end1_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign fill_next = fill_ff + LEN_W'(1);

   // Next phase and held fields for each accepted word.
   always_comb begin
      phase_in = phase_ff;
      ident_in = ident_ff;
      len_in   = len_ff;
      fill_in  = fill_ff;
      check_in = check_ff;
      wr       = '0;
      done     = '0;
      if (accept) begin
         case (phase_ff)
            PH_HEAD0: begin
               if (rx_byte == head0_ff) begin
                  phase_in = PH_HEAD1;
               end
            end
            PH_HEAD1: phase_in = (rx_byte == head1_ff) ? PH_IDENT : PH_HEAD0;
            PH_IDENT: begin
               ident_in = rx_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               fill_in = '0;
               if (rx_byte > BYTE_W'(PAYLOAD_DEPTH)) begin
                  phase_in = PH_HEAD0;
               end else begin
                  len_in   = rx_byte[LEN_W-1:0];
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               // A zero-length frame still stores one byte here.
               wr.wr_en = (fill_ff < LEN_W'(PAYLOAD_DEPTH));
               wr.addr  = fill_ff[ADDR_W-1:0];
               wr.data  = rx_byte;
               fill_in  = fill_next;
               if (fill_next >= len_ff) begin
                  phase_in = PH_CHK0;
               end
            end
            PH_CHK0: begin
               check_in = {rx_byte, check_ff[BYTE_W-1:0]};
               phase_in = PH_CHK1;
            end
            PH_CHK1: begin
               check_in = {check_ff[CHECK_W-1:BYTE_W], rx_byte};
               phase_in = PH_END0;
            end
            PH_END0: phase_in = (rx_byte == end0_ff) ? PH_END1 : PH_HEAD0;
            PH_END1: begin
               // A matching trailer releases the frame, unless it is empty.
               done.start = (rx_byte == end1_ff) && (len_ff != '0);
               done.count = len_ff;
               done.ident = ident_ff;
               done.check = check_ff;
               phase_in   = PH_HEAD0;
            end
            default: phase_in = PH_HEAD0;
         endcase
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD0;
         ident_ff <= '0;
         len_ff   <= '0;
         fill_ff  <= '0;
         check_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         ident_ff <= ident_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         check_ff <= check_in;
      end
   end

endmodule

@@ hdl/dfr_drain.sv @@
// Output sequencer: reads a finished frame out of dfr_store into the result register.
// Depends on dfr_pkg for the frame hand-over type and the field widths.
`timescale 1ns / 1ps

module dfr_drain
   import dfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  frame_done_type     done,
   output logic               rd_en,
   output logic [ADDR_W-1:0]  rd_addr,
   input  logic [BYTE_W-1:0]  rd_data,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_payload_byte,
   output logic [POS_W-1:0]   rsp_payload_pos,
   output logic [BYTE_W-1:0]  rsp_frame_ident,
   output logic [CHECK_W-1:0] rsp_check_word,
   output logic               rsp_is_last
);

   logic               active_ff;
   logic [LEN_W-1:0]   idx_ff;
   logic [LEN_W-1:0]   idx_next;
   logic [LEN_W-1:0]   total_ff;
   logic [BYTE_W-1:0]  ident_ff;
   logic [CHECK_W-1:0] check_ff;
   logic               pend_ff;
   logic [POS_W-1:0]   pend_pos_ff;
   logic               pend_last_ff;
   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic [POS_W-1:0]   out_pos_ff;
   logic [BYTE_W-1:0]  out_ident_ff;
   logic [CHECK_W-1:0] out_check_ff;
   logic               out_last_ff;
   logic               issue;
   logic               issue_last;

   // A read is issued only when the result register will be free on its return.
   assign issue      = active_ff && !pend_ff && (!out_valid_ff || !rsp_stall);
   assign idx_next   = idx_ff + LEN_W'(1);
   assign issue_last = (idx_next == total_ff);
   assign rd_en      = issue;
   assign rd_addr    = idx_ff[ADDR_W-1:0];
   assign busy       = active_ff || pend_ff;

   // Read sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         if (done.start) begin
            active_ff <= 1'b1;
         end else if (issue && issue_last) begin
            active_ff <= 1'b0;
         end
         pend_ff <= issue;
      end
   end

   // Frame fields and read bookkeeping.
   always_ff @(posedge clock) begin
      if (done.start) begin
         idx_ff   <= '0;
         total_ff <= done.count;
         ident_ff <= done.ident;
         check_ff <= done.check;
      end else if (issue) begin
         idx_ff <= idx_next;
      end
      if (issue) begin
         pend_pos_ff  <= idx_ff[POS_W-1:0];
         pend_last_ff <= issue_last;
      end
   end

   // Result register: loads a returned word, empties when it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pend_ff) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         out_byte_ff  <= rd_data;
         out_pos_ff   <= pend_pos_ff;
         out_ident_ff <= ident_ff;
         out_check_ff <= check_ff;
         out_last_ff  <= pend_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_payload_pos  = out_pos_ff;
   assign rsp_frame_ident  = out_ident_ff;
   assign rsp_check_word   = out_check_ff;
   assign rsp_is_last      = out_last_ff;

endmodule

@@ hdl/delimited_frame_receiver.sv @@
// Top level of the delimited frame receiver: parser, payload store and output sequencer.
// Depends on dfr_pkg, dfr_parser, dfr_store and dfr_drain.
//
//   Channel  Direction  Handshake          Word
//   req_     in         req_valid/stall    req_rx_byte
//   rsp_     out        rsp_valid/stall    payload byte, position, ident, check, last flag
//   csr_     in         csr_wr_en          csr_index, csr_wr_data
//
// An input byte is taken when req_valid is high and req_stall is low. After the second end
// byte of a frame, the store is read back word by word through the memory read register
// and result register, one read in flight at a time; req_stall is high until the last read
// has returned. A stall on the result side holds the result register and pauses reads.
// Reset is synchronous and needs no clearing pass; configuration returns to its defaults.
`timescale 1ns / 1ps

module delimited_frame_receiver
   import dfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_payload_byte,
   output logic [POS_W-1:0]     rsp_payload_pos,
   output logic [BYTE_W-1:0]    rsp_frame_ident,
   output logic [CHECK_W-1:0]   rsp_check_word,
   output logic                 rsp_is_last
);

   store_write_type   wr;
   frame_done_type    done;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              busy;
   logic              accept;

   // Input is held off while a frame is being read out.
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   dfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .wr          (wr),
      .done        (done)
   );

   dfr_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dfr_drain u_drain (
      .clock            (clock),
      .reset            (reset),
      .done             (done),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_pos  (rsp_payload_pos),
      .rsp_frame_ident  (rsp_frame_ident),
      .rsp_check_word   (rsp_check_word),
      .rsp_is_last      (rsp_is_last)
   );

endmodule

@@ hdl/dfr_checker.sv @@
// Port-level checks for the delimited frame receiver, bound to the top level.
// Depends on dfr_pkg for the field widths.
`timescale 1ns / 1ps

module dfr_checker
   import dfr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [BYTE_W-1:0]  rsp_payload_byte,
   input logic [POS_W-1:0]   rsp_payload_pos,
   input logic [BYTE_W-1:0]  rsp_frame_ident,
   input logic [CHECK_W-1:0] rsp_check_word,
   input logic               rsp_is_last
);

   // A stalled result word stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_payload_pos) && $stable(rsp_is_last))
      else $error("stalled result word changed");

   // No result is shown straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // While a frame is still being read out, input is held off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> req_stall)
      else $error("input taken during frame read-out");

   // A word that follows a taken word of the same frame is at the next position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_is_last |=> !rsp_valid
         || (rsp_payload_pos == $past(rsp_payload_pos) + POS_W'(1)
             && rsp_frame_ident == $past(rsp_frame_ident)
             && rsp_check_word == $past(rsp_check_word)))
      else $error("payload position or frame fields out of sequence");

endmodule

bind delimited_frame_receiver dfr_checker u_dfr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_payload_pos  (rsp_payload_pos),
   .rsp_frame_ident  (rsp_frame_ident),
   .rsp_check_word   (rsp_check_word),
   .rsp_is_last      (rsp_is_last)
);

@@ test/tb.sv @@
// Self-checking testbench for the delimited frame receiver: a clocked driver and monitor
// around the top level, with a parser predictor that mirrors the frame format word by word.
// Depends on dfr_pkg and the delimited_frame_receiver RTL.
`timescale 1ns / 1ps

module tb;
   import dfr_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_SETTINGS  = 5;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [7:0] DEF_HEAD0 = 8'hFC;
   localparam logic [7:0] DEF_HEAD1 = 8'hFB;
   localparam logic [7:0] DEF_END0  = 8'hFD;
   localparam logic [7:0] DEF_END1  = 8'hFE;

   typedef enum logic [8:0] {
      SEEK_HEAD0  = 9'b000000001,
      SEEK_HEAD1  = 9'b000000010,
      TAKE_IDENT  = 9'b000000100,
      TAKE_LENGTH = 9'b000001000,
      TAKE_DATA   = 9'b000010000,
      TAKE_CHECK0 = 9'b000100000,
      TAKE_CHECK1 = 9'b001000000,
      SEEK_END0   = 9'b010000000,
      SEEK_END1   = 9'b100000000
   } parse_step_type;

   typedef enum int {
      FRAME_GOOD, FRAME_BAD_HEAD1, FRAME_OVERLONG, FRAME_BAD_END0, FRAME_BAD_END1
   } frame_kind_type;

   typedef struct {
      logic [BYTE_W-1:0]  data;
      logic [POS_W-1:0]   pos;
      logic [BYTE_W-1:0]  ident;
      logic [CHECK_W-1:0] check;
      logic               last;
   } payload_word_type;

   // Block ports.
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_HEAD_BYTE_0;
   logic [BYTE_W-1:0]    csr_wr_data = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic [POS_W-1:0]     rsp_payload_pos;
   logic [BYTE_W-1:0]    rsp_frame_ident;
   logic [CHECK_W-1:0]   rsp_check_word;
   logic                 rsp_is_last;

   // Stimulus bookkeeping.
   logic [BYTE_W-1:0] pending_bytes[$];
   payload_word_type  expected_words[$];
   int send_gap     = 0;
   int burst_left   = 0;
   int send_pick    = 0;
   int stall_hold   = 0;
   int stall_pick   = 0;
   int cycle_count  = 0;
   int bytes_queued = 0;
   int planned_results = 0;
   int bytes_accepted  = 0;
   int words_checked   = 0;
   int frames_done     = 0;
   int mismatch_count  = 0;

   // Predictor state and its copy of the match registers.
   parse_step_type     parse_state;
   logic [BYTE_W-1:0]  cfg_head0, cfg_head1, cfg_end0, cfg_end1;
   logic [BYTE_W-1:0]  held_ident;
   logic [LEN_W-1:0]   held_length;
   logic [LEN_W-1:0]   fill_count;
   logic [CHECK_W-1:0] held_check;
   logic [BYTE_W-1:0]  payload_copy [PAYLOAD_DEPTH];

   delimited_frame_receiver i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_pos  (rsp_payload_pos),
      .rsp_frame_ident  (rsp_frame_ident),
      .rsp_check_word   (rsp_check_word),
      .rsp_is_last      (rsp_is_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advances the frame parser by one received byte and queues the words a completed
   // frame releases.
   task automatic advance_parser(input logic [BYTE_W-1:0] rx);
      payload_word_type w;
      int n;
      case (parse_state)
         SEEK_HEAD0: begin
            if (rx == cfg_head0) parse_state = SEEK_HEAD1;
         end
         SEEK_HEAD1: begin
            parse_state = (rx == cfg_head1) ? TAKE_IDENT : SEEK_HEAD0;
         end
         TAKE_IDENT: begin
            held_ident  = rx;
            parse_state = TAKE_LENGTH;
         end
         TAKE_LENGTH: begin
            fill_count = '0;
            if (rx > PAYLOAD_DEPTH) begin
               parse_state = SEEK_HEAD0;
            end else begin
               held_length = rx[LEN_W-1:0];
               parse_state = TAKE_DATA;
            end
         end
         TAKE_DATA: begin
            // A zero length still stores one byte before the check bytes.
            if (fill_count < PAYLOAD_DEPTH) payload_copy[fill_count[POS_W-1:0]] = rx;
            fill_count = fill_count + 1'b1;
            if (fill_count >= held_length) parse_state = TAKE_CHECK0;
         end
         TAKE_CHECK0: begin
            held_check[15:8] = rx;
            parse_state      = TAKE_CHECK1;
         end
         TAKE_CHECK1: begin
            held_check[7:0] = rx;
            parse_state     = SEEK_END0;
         end
         SEEK_END0: begin
            parse_state = (rx == cfg_end0) ? SEEK_END1 : SEEK_HEAD0;
         end
         SEEK_END1: begin
            if (rx == cfg_end1) begin
               n = (held_length > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : held_length;
               for (int i = 0; i < n; i++) begin
                  w.data  = payload_copy[i];
                  w.pos   = i[POS_W-1:0];
                  w.ident = held_ident;
                  w.check = held_check;
                  w.last  = (i + 1 == n);
                  expected_words.push_back(w);
               end
               frames_done++;
            end
            parse_state = SEEK_HEAD0;
         end
         default: parse_state = SEEK_HEAD0;
      endcase
   endtask

   // Byte driver: takes words from the pending queue with random gaps and gap-free bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         send_gap   <= 0;
         burst_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
               send_gap   <= 0;
            end else begin
               send_pick = $urandom_range(0, 99);
               if (send_pick < 5) begin
                  burst_left <= $urandom_range(20, 60);
                  send_gap   <= 0;
               end else if (send_pick < 45) begin
                  send_gap <= 0;
               end else if (send_pick < 80) begin
                  send_gap <= $urandom_range(1, 3);
               end else if (send_pick < 94) begin
                  send_gap <= $urandom_range(4, 12);
               end else begin
                  send_gap <= $urandom_range(20, 60);
               end
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result-side back-pressure: short stalls mostly, some long ones, and stall-free stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 50) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 6);
         end else if (stall_pick < 82) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 2);
         end else if (stall_pick < 94) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(3, 20);
         end else begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(30, 80);
         end
      end
   end

   // Monitor: tracks register writes, checks each result word against the oldest
   // prediction and feeds every accepted byte to the predictor.
   always @(posedge clock) begin
      payload_word_type want;
      if (reset) begin
         parse_state = SEEK_HEAD0;
         cfg_head0   = DEF_HEAD0;
         cfg_head1   = DEF_HEAD1;
         cfg_end0    = DEF_END0;
         cfg_end1    = DEF_END1;
         held_ident  = '0;
         held_length = '0;
         fill_count  = '0;
         held_check  = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HEAD_BYTE_0: cfg_head0 = csr_wr_data;
               CSR_HEAD_BYTE_1: cfg_head1 = csr_wr_data;
               CSR_END_BYTE_0:  cfg_end0  = csr_wr_data;
               CSR_END_BYTE_1:  cfg_end1  = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected word: data %h pos %0d ident %h check %h last %b",
                           $realtime, rsp_payload_byte, rsp_payload_pos, rsp_frame_ident,
                           rsp_check_word, rsp_is_last);
            end else begin
               want = expected_words.pop_front();
               if (rsp_payload_byte !== want.data || rsp_payload_pos !== want.pos ||
                   rsp_frame_ident !== want.ident || rsp_check_word !== want.check ||
                   rsp_is_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: word mismatch", $realtime);
                     $display("   expected data %h pos %0d ident %h check %h last %b",
                              want.data, want.pos, want.ident, want.check, want.last);
                     $display("   got      data %h pos %0d ident %h check %h last %b",
                              rsp_payload_byte, rsp_payload_pos, rsp_frame_ident,
                              rsp_check_word, rsp_is_last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            bytes_accepted++;
            advance_parser(req_rx_byte);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
         $display("delimited_frame_receiver test failed");
         $finish;
      end
   end

   task automatic queue_byte(input logic [BYTE_W-1:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   // Random byte with the all-zero and all-one values favoured.
   function automatic logic [BYTE_W-1:0] rand_byte();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] avoid);
      logic [BYTE_W-1:0] v;
      v = rand_byte();
      while (v == avoid) v = rand_byte();
      return v;
   endfunction

   // Queues one frame, cut short or spoilt where the kind asks for it.
   task automatic queue_frame(input logic [BYTE_W-1:0] ident, input int len,
                              input logic [CHECK_W-1:0] check, input frame_kind_type kind);
      int k;
      queue_byte(cfg_head0);
      if (kind == FRAME_BAD_HEAD1) begin
         queue_byte(other_than(cfg_head1));
         return;
      end
      queue_byte(cfg_head1);
      queue_byte(ident);
      queue_byte(len[7:0]);
      if (kind == FRAME_OVERLONG) return;
      for (k = 0; k < ((len == 0) ? 1 : len); k++) queue_byte(rand_byte());
      queue_byte(check[15:8]);
      queue_byte(check[7:0]);
      if (kind == FRAME_BAD_END0) begin
         queue_byte(other_than(cfg_end0));
         return;
      end
      queue_byte(cfg_end0);
      if (kind == FRAME_BAD_END1) begin
         queue_byte(other_than(cfg_end1));
         return;
      end
      queue_byte(cfg_end1);
      planned_results += len;
   endtask

   // Waits until every byte is taken, every word has come back and the block has been
   // quiet for the given number of cycles.
   task automatic wait_for_drain(input int quiet_needed);
      int quiet;
      quiet = 0;
      while (quiet < quiet_needed) begin
         @(negedge clock);
         if (pending_bytes.size() == 0 && !req_valid && !req_stall &&
             expected_words.size() == 0)
            quiet++;
         else
            quiet = 0;
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic write_match_bytes(input logic [BYTE_W-1:0] h0, input logic [BYTE_W-1:0] h1,
                                    input logic [BYTE_W-1:0] e0, input logic [BYTE_W-1:0] e1);
      write_csr(CSR_HEAD_BYTE_0, h0);
      write_csr(CSR_HEAD_BYTE_1, h1);
      write_csr(CSR_END_BYTE_0, e0);
      write_csr(CSR_END_BYTE_1, e1);
   endtask

   // Stimulus: directed frames under the reset defaults, then random traffic under the
   // all-zero, all-one and a random setting, and a full buffer with the defaults written back.
   initial begin
      int phase_results;
      int pick;
      int len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
         if (setting > 0) begin
            wait_for_drain(12);
            case (setting)
               1: write_match_bytes(8'h00, 8'h00, 8'h00, 8'h00);
               2: write_match_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
               3: write_match_bytes(BYTE_W'($urandom_range(0, 255)),
                                    BYTE_W'($urandom_range(0, 255)),
                                    BYTE_W'($urandom_range(0, 255)),
                                    BYTE_W'($urandom_range(0, 255)));
               default: write_match_bytes(DEF_HEAD0, DEF_HEAD1, DEF_END0, DEF_END1);
            endcase
         end
         @(negedge clock);

         if (setting == 0) begin
            // The first header byte again in place of the second: the hunt restarts
            // without taking that byte as a new first header byte.
            queue_byte(cfg_head0);
            queue_byte(cfg_head0);
            // Zero length: one stored byte, no words out.
            queue_frame(8'hFF, 0, 16'hFF00, FRAME_GOOD);
            // Lengths just above the buffer depth and at the top of the byte range.
            queue_frame(8'h00, PAYLOAD_DEPTH + 1, 16'h0000, FRAME_OVERLONG);
            queue_frame(8'h5A, 255, 16'h0000, FRAME_OVERLONG);
            // Trailer mismatches on either end byte drop the frame.
            queue_frame(8'h3C, 1, 16'h1234, FRAME_BAD_END0);
            queue_frame(8'hC3, 1, 16'h5678, FRAME_BAD_END1);
         end else if (setting == NUM_SETTINGS - 1) begin
            // A full buffer: every position is written and read back.
            queue_frame(rand_byte(), PAYLOAD_DEPTH, {rand_byte(), rand_byte()}, FRAME_GOOD);
         end else begin
            // Random part: noise and broken frames until a frame with payload completes.
            phase_results = planned_results;
            while (planned_results - phase_results < 1) begin
               pick = $urandom_range(0, 99);
               if (pick < 65) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 10)      len = 0;
                  else if (pick < 85) len = $urandom_range(1, 6);
                  else if (pick < 97) len = $urandom_range(7, 20);
                  else                len = $urandom_range(21, PAYLOAD_DEPTH - 1);
                  queue_frame(rand_byte(), len, {rand_byte(), rand_byte()}, FRAME_GOOD);
               end else if (pick < 72) begin
                  repeat ($urandom_range(1, 4)) queue_byte(other_than(cfg_head0));
               end else if (pick < 79) begin
                  queue_frame(rand_byte(), 1, 16'h0000, FRAME_BAD_HEAD1);
               end else if (pick < 85) begin
                  queue_frame(rand_byte(), $urandom_range(PAYLOAD_DEPTH + 1, 255), 16'h0000,
                              FRAME_OVERLONG);
               end else if (pick < 92) begin
                  queue_frame(rand_byte(), $urandom_range(0, 4), {rand_byte(), rand_byte()},
                              FRAME_BAD_END0);
               end else begin
                  queue_frame(rand_byte(), $urandom_range(0, 4), {rand_byte(), rand_byte()},
                              FRAME_BAD_END1);
               end
            end
         end
      end

      wait_for_drain(40);
      if (expected_words.size() != 0) begin
         $display("%0d predicted words never arrived.", expected_words.size());
         mismatch_count += expected_words.size();
      end
      $display("Sent %0d bytes under %0d match-byte settings; %0d frames completed.",
               bytes_accepted, NUM_SETTINGS, frames_done);
      $display("Checked %0d payload words; %0d failures.", words_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("delimited_frame_receiver test passed");
      end else begin
         $display("delimited_frame_receiver test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/dfr_pkg.sv
hdl/dfr_store.sv
hdl/dfr_parser.sv
hdl/dfr_drain.sv
hdl/delimited_frame_receiver.sv
hdl/dfr_checker.sv
test/tb.sv
